// ===== hdl/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion block
package rmq_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = DATA_WIDTH - 2;
	// signed width of t and of the off-diagonal sums
	localparam int SUM_WIDTH  = DATA_WIDTH + 2;
	// magnitude width of a term, also the width of a positive t
	localparam int MAG_WIDTH  = DATA_WIDTH + 1;
	// width of mag^2 scaled by 2^FRAC_BITS
	localparam int REM_WIDTH  = 3 * DATA_WIDTH;
	// signed accumulator width for the root search
	localparam int ACC_WIDTH  = 3 * DATA_WIDTH + 5;
	localparam int LANES      = 4;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m_xx;
		logic signed [DATA_WIDTH-1:0] m_xy;
		logic signed [DATA_WIDTH-1:0] m_xz;
		logic signed [DATA_WIDTH-1:0] m_yx;
		logic signed [DATA_WIDTH-1:0] m_yy;
		logic signed [DATA_WIDTH-1:0] m_yz;
		logic signed [DATA_WIDTH-1:0] m_zx;
		logic signed [DATA_WIDTH-1:0] m_zy;
		logic signed [DATA_WIDTH-1:0] m_zz;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
		logic signed [DATA_WIDTH-1:0] quat_w;
		logic                         degenerate;
	} quat_t;

	// one component in the bit-by-bit root search
	typedef struct packed {
		logic [DATA_WIDTH-1:0]        n;
		logic signed [ACC_WIDTH-1:0]  p;   // (2n-1)^2 * t
		logic signed [ACC_WIDTH-1:0]  q;   // (2n-1) * t
		logic [REM_WIDTH-1:0]         r;   // mag^2 * 2^FRAC_BITS
		logic                         pos;
		logic                         neg;
	} lane_t;

	typedef struct packed {
		logic [MAG_WIDTH-1:0]   t;
		logic                   degen;
		lane_t [LANES-1:0]      lanes;
	} work_t;

endpackage

// ===== hdl/rmq_front.sv =====
// branch select, trace term and squared magnitudes (two stages)
module rmq_front import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  mat_t  mat,
	output logic  valid_out,
	output work_t work
);

	logic                        valid_s1;
	logic signed [SUM_WIDTH-1:0] t_s1;
	logic signed [SUM_WIDTH-1:0] v_s1 [LANES];
	logic                        valid_s2;
	work_t                       work_s2;

	logic signed [SUM_WIDTH-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, one;
	logic signed [SUM_WIDTH-1:0] t_c;
	logic signed [SUM_WIDTH-1:0] v_c [LANES];

	// branch and sums
	always_comb begin
		xx  = SUM_WIDTH'(mat.m_xx);
		xy  = SUM_WIDTH'(mat.m_xy);
		xz  = SUM_WIDTH'(mat.m_xz);
		yx  = SUM_WIDTH'(mat.m_yx);
		yy  = SUM_WIDTH'(mat.m_yy);
		yz  = SUM_WIDTH'(mat.m_yz);
		zx  = SUM_WIDTH'(mat.m_zx);
		zy  = SUM_WIDTH'(mat.m_zy);
		zz  = SUM_WIDTH'(mat.m_zz);
		one = SUM_WIDTH'(1) <<< FRAC_BITS;
		if (zz < 0) begin
			if (xx > yy) begin
				t_c = one + xx - yy - zz;
				v_c[0] = t_c; v_c[1] = xy + yx; v_c[2] = zx + xz; v_c[3] = yz - zy;
			end else begin
				t_c = one - xx + yy - zz;
				v_c[0] = xy + yx; v_c[1] = t_c; v_c[2] = yz + zy; v_c[3] = zx - xz;
			end
		end else begin
			if (xx + yy < 0) begin
				t_c = one - xx - yy + zz;
				v_c[0] = zx + xz; v_c[1] = yz + zy; v_c[2] = t_c; v_c[3] = xy - yx;
			end else begin
				t_c = one + xx + yy + zz;
				v_c[0] = yz - zy; v_c[1] = zx - xz; v_c[2] = xy - yx; v_c[3] = t_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_c;
			v_s1 <= v_c;
		end
	end

	// magnitudes, squares and search start values
	logic [MAG_WIDTH-1:0]        mag   [LANES];
	logic [2*MAG_WIDTH-1:0]      sq    [LANES];
	logic [MAG_WIDTH-1:0]        t_pos;
	logic signed [ACC_WIDTH-1:0] t_acc;
	work_t                       work_c;

	always_comb begin
		t_pos = t_s1[MAG_WIDTH-1:0];
		t_acc = signed'({{(ACC_WIDTH-MAG_WIDTH){1'b0}}, t_pos});
		work_c.t     = t_pos;
		work_c.degen = (t_s1 <= 0);
		for (int i = 0; i < LANES; i++) begin
			mag[i] = v_s1[i][SUM_WIDTH-1] ? MAG_WIDTH'(-v_s1[i]) : MAG_WIDTH'(v_s1[i]);
			sq[i]  = mag[i] * mag[i];
			work_c.lanes[i].n   = '0;
			work_c.lanes[i].p   = t_acc;
			work_c.lanes[i].q   = -t_acc;
			work_c.lanes[i].r   = REM_WIDTH'({sq[i], {FRAC_BITS{1'b0}}});
			work_c.lanes[i].pos = (v_s1[i] > 0);
			work_c.lanes[i].neg = v_s1[i][SUM_WIDTH-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s2 <= work_c;
		end
	end

	assign valid_out = valid_s2;
	assign work      = work_s2;

endmodule

// ===== hdl/rmq_step.sv =====
// one bit of the scaled root search for all four components
module rmq_step import rmq_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  work_t work_in,
	output logic  valid_out,
	output work_t work_out
);

	logic                        valid_sn;
	work_t                       work_sn;
	work_t                       work_c;
	logic signed [ACC_WIDTH-1:0] t_acc;
	logic signed [ACC_WIDTH-1:0] pc [LANES];
	logic signed [ACC_WIDTH-1:0] qc [LANES];
	logic                        fit [LANES];

	// candidate n | 2^BIT, (2c-1)^2 t grown by shifts and adds only
	always_comb begin
		work_c = work_in;
		t_acc  = signed'({{(ACC_WIDTH-MAG_WIDTH){1'b0}}, work_in.t});
		for (int i = 0; i < LANES; i++) begin
			pc[i]  = work_in.lanes[i].p + (work_in.lanes[i].q <<< (BIT + 2))
			       + (t_acc <<< (2 * BIT + 2));
			qc[i]  = work_in.lanes[i].q + (t_acc <<< (BIT + 1));
			fit[i] = (pc[i] <= signed'({{(ACC_WIDTH-REM_WIDTH){1'b0}},
			          work_in.lanes[i].r}));
			// once the top bit is taken the value is final
			if (fit[i] && !work_in.lanes[i].n[DATA_WIDTH-1]) begin
				work_c.lanes[i].n[BIT] = 1'b1;
				work_c.lanes[i].p      = pc[i];
				work_c.lanes[i].q      = qc[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_sn <= work_c;
		end
	end

	assign valid_out = valid_sn;
	assign work_out  = work_sn;

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// top level: rotation matrix to quaternion conversion pipeline
//
// Input channel in_valid/in_stall/in_data carries one 3x3 rotation matrix
// (nine signed Q2.14 elements) per request. Output channel
// out_valid/out_stall/out_data carries the quaternion x, y, z, w in Q2.14
// plus a degenerate flag, which is set with all components zero when the
// chosen trace term is not positive; other results saturate.
// The pipeline has two front stages for branch select and squares, one
// stage per result bit of the shift-and-add root search, and the output
// register. One request is taken every cycle while no result waits stalled
// on the output; the root search chain sets the depth of the pipeline.
// Reset clears every valid bit; the pipeline comes out of reset empty.
// While out_stall holds a waiting result the whole pipeline freezes and
// in_stall rises; nothing is dropped or repeated, and the pipe moves again
// in the same cycle that the waiting result is taken.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  mat_t  in_data,
	output logic  out_valid,
	input  logic  out_stall,
	output quat_t out_data
);

	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	logic  en;
	logic  valid_q;
	quat_t data_q;
	logic  chain_valid [DATA_WIDTH+1];
	work_t chain_work  [DATA_WIDTH+1];

	// hold everything while a result waits on the output
	assign en       = !(valid_q && out_stall);
	assign in_stall = !en;

	rmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (in_valid),
		.mat       (in_data),
		.valid_out (chain_valid[0]),
		.work      (chain_work[0])
	);

	// one stage per result bit, top bit first
	for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
		rmq_step #(.BIT(DATA_WIDTH - 1 - g)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (chain_valid[g]),
			.work_in   (chain_work[g]),
			.valid_out (chain_valid[g+1]),
			.work_out  (chain_work[g+1])
		);
	end

	// sign, saturation and degenerate case
	logic [DATA_WIDTH-1:0] comp [LANES];
	quat_t                 res_c;
	work_t                 last;

	always_comb begin
		last = chain_work[DATA_WIDTH];
		for (int i = 0; i < LANES; i++) begin
			if (last.degen) begin
				comp[i] = '0;
			end else if (last.lanes[i].pos) begin
				comp[i] = last.lanes[i].n[DATA_WIDTH-1] ? MAX_POS : last.lanes[i].n;
			end else if (last.lanes[i].neg) begin
				comp[i] = -last.lanes[i].n;
			end else begin
				comp[i] = '0;
			end
		end
		res_c.quat_x     = signed'(comp[0]);
		res_c.quat_y     = signed'(comp[1]);
		res_c.quat_z     = signed'(comp[2]);
		res_c.quat_w     = signed'(comp[3]);
		res_c.degenerate = last.degen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= chain_valid[DATA_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= res_c;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== verif/rotation_matrix_to_quaternion_tb.sv =====
// testbench for the rotation matrix to quaternion pipeline, self-checking
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
	import rmq_pkg::*;

	localparam int  CLK_HALF    = 6;
	localparam int  RESET_CYCLES = 12;
	localparam int  DRAIN_CYCLES = DATA_WIDTH + 3 + 20;
	localparam int  CYCLE_LIMIT  = 200000;
	localparam int  PHASE_ITEMS  = 95;
	localparam longint ONE_FIX   = 64'sd1 <<< FRAC_BITS;
	localparam longint HALF_RANGE = 64'sd1 <<< (DATA_WIDTH - 1);

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	mat_t  in_data;
	logic  out_valid;
	logic  out_stall;
	quat_t out_data;

	mat_t  pending_mats[$];
	quat_t expected_quats[$];
	int    send_idle_pct;
	int    recv_stall_pct;
	int    error_count;
	int    cycle_count;
	logic  run_done;

	rotation_matrix_to_quaternion dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// true when (2n-1)^2 * t <= mag^2 * 2^F
	function automatic logic root_fits(longint n, longint t, longint mag);
		logic [127:0] lhs;
		logic [127:0] rhs;
		lhs = 128'(2 * n - 1) * 128'(2 * n - 1) * 128'(t);
		rhs = (128'(mag) * 128'(mag)) << FRAC_BITS;
		return lhs <= rhs;
	endfunction

	// one component: nearest integer to v * 2^(F/2) / (2 sqrt t), saturated
	function automatic logic signed [DATA_WIDTH-1:0] scaled_component(longint v, longint t);
		longint mag;
		longint n;
		longint cand;
		mag = (v < 0) ? -v : v;
		n = 0;
		if (mag == 0)
			return '0;
		if (root_fits(HALF_RANGE, t, mag)) begin
			n = HALF_RANGE;
		end else begin
			for (int b = DATA_WIDTH - 2; b >= 0; b--) begin
				cand = n | (64'sd1 <<< b);
				if (root_fits(cand, t, mag))
					n = cand;
			end
		end
		if (v > 0) begin
			if (n > HALF_RANGE - 1)
				n = HALF_RANGE - 1;
			return n[DATA_WIDTH-1:0];
		end
		return DATA_WIDTH'(-n);
	endfunction

	// branch select, trace term and off-diagonal sums, then scaling
	function automatic quat_t predict_quat(mat_t m);
		longint xx, xy, xz, yx, yy, yz, zx, zy, zz;
		longint t;
		longint v[4];
		quat_t  q;
		xx = m.m_xx; xy = m.m_xy; xz = m.m_xz;
		yx = m.m_yx; yy = m.m_yy; yz = m.m_yz;
		zx = m.m_zx; zy = m.m_zy; zz = m.m_zz;
		if (zz < 0) begin
			if (xx > yy) begin
				t = ONE_FIX + xx - yy - zz;
				v[0] = t; v[1] = xy + yx; v[2] = zx + xz; v[3] = yz - zy;
			end else begin
				t = ONE_FIX - xx + yy - zz;
				v[0] = xy + yx; v[1] = t; v[2] = yz + zy; v[3] = zx - xz;
			end
		end else begin
			if (xx < -yy) begin
				t = ONE_FIX - xx - yy + zz;
				v[0] = zx + xz; v[1] = yz + zy; v[2] = t; v[3] = xy - yx;
			end else begin
				t = ONE_FIX + xx + yy + zz;
				v[0] = yz - zy; v[1] = zx - xz; v[2] = xy - yx; v[3] = t;
			end
		end
		q = '0;
		if (t <= 0) begin
			q.degenerate = 1'b1;
		end else begin
			q.quat_x = scaled_component(v[0], t);
			q.quat_y = scaled_component(v[1], t);
			q.quat_z = scaled_component(v[2], t);
			q.quat_w = scaled_component(v[3], t);
		end
		return q;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] to_fix(real r);
		longint k;
		k = longint'(r * real'(ONE_FIX));
		if (k > HALF_RANGE - 1)
			k = HALF_RANGE - 1;
		if (k < -HALF_RANGE)
			k = -HALF_RANGE;
		return k[DATA_WIDTH-1:0];
	endfunction

	// true rotation from a random unit quaternion, with optional small noise
	function automatic mat_t random_rotation(int noise);
		real a, b, c, d, s;
		mat_t m;
		a = real'($urandom_range(2000)) - 1000.0;
		b = real'($urandom_range(2000)) - 1000.0;
		c = real'($urandom_range(2000)) - 1000.0;
		d = real'($urandom_range(2000)) - 1000.0;
		s = $sqrt(a * a + b * b + c * c + d * d);
		if (s == 0.0) begin
			a = 1.0; s = 1.0;
		end
		a = a / s; b = b / s; c = c / s; d = d / s;
		// a is w, b c d are x y z
		m.m_xx = to_fix(1.0 - 2.0 * (c * c + d * d));
		m.m_xy = to_fix(2.0 * (b * c - a * d));
		m.m_xz = to_fix(2.0 * (b * d + a * c));
		m.m_yx = to_fix(2.0 * (b * c + a * d));
		m.m_yy = to_fix(1.0 - 2.0 * (b * b + d * d));
		m.m_yz = to_fix(2.0 * (c * d - a * b));
		m.m_zx = to_fix(2.0 * (b * d - a * c));
		m.m_zy = to_fix(2.0 * (c * d + a * b));
		m.m_zz = to_fix(1.0 - 2.0 * (b * b + c * c));
		if (noise > 0) begin
			m.m_xy = m.m_xy + DATA_WIDTH'($urandom_range(2 * noise) - noise);
			m.m_zz = m.m_zz + DATA_WIDTH'($urandom_range(2 * noise) - noise);
			m.m_xx = m.m_xx + DATA_WIDTH'($urandom_range(2 * noise) - noise);
		end
		return m;
	endfunction

	function automatic mat_t diag_mat(int xx, int yy, int zz, int off);
		mat_t m;
		m = '{default: DATA_WIDTH'(off)};
		m.m_xx = DATA_WIDTH'(xx);
		m.m_yy = DATA_WIDTH'(yy);
		m.m_zz = DATA_WIDTH'(zz);
		return m;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want,
			cycle_count);
		error_count++;
	endtask

	// record the request at the edge where it is taken
	logic in_taken;
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			expected_quats.push_back(predict_quat(in_data));
		end
	end

	// driver: new request or idle at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data  <= pending_mats.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_quats.size() == 0) begin
				$display("unexpected result at cycle %0d", cycle_count);
				error_count++;
			end else begin
				want = expected_quats.pop_front();
				if (out_data.quat_x !== want.quat_x)
					report_mismatch("quat_x", out_data.quat_x, want.quat_x);
				if (out_data.quat_y !== want.quat_y)
					report_mismatch("quat_y", out_data.quat_y, want.quat_y);
				if (out_data.quat_z !== want.quat_z)
					report_mismatch("quat_z", out_data.quat_z, want.quat_z);
				if (out_data.quat_w !== want.quat_w)
					report_mismatch("quat_w", out_data.quat_w, want.quat_w);
				if (out_data.degenerate !== want.degenerate)
					report_mismatch("degenerate", out_data.degenerate, want.degenerate);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT && !run_done) begin
			$display("timeout with %0d results outstanding", expected_quats.size());
			$display("rotation_matrix_to_quaternion_tb: FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		mat_t m;
		in_valid       = 1'b0;
		in_data        = '0;
		out_stall      = 1'b0;
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		cycle_count    = 0;
		run_done       = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity, each branch, branch boundaries, field extremes
		pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
		pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));
		pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));
		pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));
		pending_mats.push_back(diag_mat(100, 100, -1, 5));
		pending_mats.push_back(diag_mat(100, -100, 0, -5));
		pending_mats.push_back(diag_mat(0, 0, 0, 0));
		pending_mats.push_back(diag_mat(-32768, -32768, -32768, -32768));
		pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
		pending_mats.push_back(diag_mat(-32768, 32767, -32768, 32767));
		pending_mats.push_back(diag_mat(32767, -32768, -32768, -32768));
		pending_mats.push_back(diag_mat(-32768, -32768, 32767, 32767));
		pending_mats.push_back(diag_mat(-32768, -32767, 0, 32767));
		pending_mats.push_back(diag_mat(-1, -1, -32768, -32768));
		pending_mats.push_back(diag_mat(-32768, 32767, 0, -1));
		m = diag_mat(-16384, -16384, 16384, 0);
		m.m_xy = 16'sh7fff; m.m_yx = 16'sh7fff; m.m_zx = 16'sh8000; m.m_xz = 16'sh8000;
		pending_mats.push_back(m);
		m = diag_mat(-32768, -32768, 0, 0);
		m.m_yz = 16'sh7fff; m.m_zy = 16'sh8000;
		pending_mats.push_back(m);
		pending_mats.push_back(random_rotation(0));

		// phases of idling; each starts once the pipe has fully drained
		for (int phase = 0; phase < 4; phase++) begin
			while (pending_mats.size() > 0 || in_valid || expected_quats.size() > 0)
				@(posedge clk);
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 65) begin
					pending_mats.push_back(random_rotation($urandom_range(1) * 300));
				end else begin
					m = mat_t'($bits(mat_t)'({$urandom, $urandom, $urandom, $urandom,
						$urandom}));
					pending_mats.push_back(m);
				end
			end
		end

		while (pending_mats.size() > 0 || in_valid || expected_quats.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		run_done = 1'b1;
		if (error_count == 0)
			$display("rotation_matrix_to_quaternion_tb: PASS");
		else
			$display("rotation_matrix_to_quaternion_tb: FAIL");
		$finish;
	end

endmodule
